[src/f32asm_pkg.sv]
// Package with the types, constants and helper functions of the binary32 add, subtract and multiply unit.
package f32asm_pkg;

  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW = 8;
  localparam int unsigned SigW = FracW + 1;
  localparam int unsigned ProdW = 2 * SigW;
  localparam int unsigned ExpBias = 127;
  localparam int unsigned MaxFiniteExp = 254;
  localparam int unsigned ExtExpW = 11;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_MUL_ALT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic a_sign;
    logic [ExpW-1:0] a_exp;
    logic [FracW-1:0] a_man;
    logic b_sign;
    logic [ExpW-1:0] b_exp;
    logic [FracW-1:0] b_man;
  } req_t;

  typedef struct packed {
    logic r_sign;
    logic [ExpW-1:0] r_exp;
    logic [FracW-1:0] r_man;
    logic [1:0] status;
  } rsp_t;

  // Item after operand unpacking and alignment or multiplication.
  typedef struct packed {
    logic is_mul;
    logic is_sub;
    logic sign;
    logic signed [ExtExpW-1:0] exp;
    logic [ProdW-1:0] val;
  } mid_t;

  // Item ready for the final packing step.
  typedef struct packed {
    logic sign;
    logic force_zero_sign;
    logic signed [ExtExpW-1:0] exp;
    logic [SigW-1:0] sig;
  } fin_t;

  function automatic logic [$clog2(ProdW+1)-1:0] lead_zeros(input logic [ProdW-1:0] v);
    logic [$clog2(ProdW+1)-1:0] n;
    logic found;
    n = ($clog2(ProdW+1))'(ProdW);
    found = 1'b0;
    for (int i = ProdW - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = ($clog2(ProdW+1))'(ProdW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

[src/f32asm_front.sv]
// Front stage: operand unpacking, alignment with add or subtract, and significand multiply.
module f32asm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  f32asm_pkg::req_t    req_i,
  output logic                valid_o,
  output f32asm_pkg::mid_t    mid_o
);
  import f32asm_pkg::*;

  logic [SigW-1:0] ga, gb, gl, gs, al_t, al_r;
  logic [ExpW-1:0] ea, eb, el, d;
  logic sa, sb, a_big, is_mul, is_sub;
  logic [SigW:0] rnd;
  mid_t mid_d, mid_q;
  logic valid_q;

  always_comb begin
    ea = (req_i.a_exp == '0) ? ExpW'(1) : req_i.a_exp;
    eb = (req_i.b_exp == '0) ? ExpW'(1) : req_i.b_exp;
    ga = {(req_i.a_exp != '0), req_i.a_man};
    gb = {(req_i.b_exp != '0), req_i.b_man};
    is_mul = req_i.req_type[1];
    sa = req_i.a_sign;
    sb = req_i.b_sign ^ (req_i.req_type == OP_SUB);
    a_big = (ea > eb) || ((ea == eb) && (ga >= gb));
    gl = a_big ? ga : gb;
    gs = a_big ? gb : ga;
    el = a_big ? ea : eb;
    d = a_big ? (ea - eb) : (eb - ea);
    is_sub = (sa != sb);
    al_t = (d >= ExpW'(SigW)) ? '0 : (gs >> d);
    rnd = '0;
    if (d == '0) begin
      al_r = gs;
    end else if (d > ExpW'(SigW)) begin
      al_r = '0;
    end else begin
      rnd = ({1'b0, gs} + ((SigW+1)'(1) << (d - ExpW'(1)))) >> d;
      al_r = rnd[SigW-1:0];
    end
    mid_d.is_mul = is_mul;
    mid_d.is_sub = is_sub && !is_mul;
    if (is_mul) begin
      mid_d.sign = req_i.a_sign ^ req_i.b_sign;
      mid_d.exp = ExtExpW'(ea) + ExtExpW'(eb) - ExtExpW'(ExpBias);
      mid_d.val = ga * gb;
    end else begin
      mid_d.sign = a_big ? sa : sb;
      mid_d.exp = ExtExpW'(el);
      if (is_sub) begin
        mid_d.val = (al_r > gl) ? '0 : ProdW'(gl - al_r);
      end else begin
        mid_d.val = ProdW'(gl) + ProdW'(al_t);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = valid_q;
  assign mid_o = mid_q;
endmodule

[src/f32asm_norm.sv]
// Normalize stage: leading-zero count and shift into a 24-bit significand.
module f32asm_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  f32asm_pkg::mid_t    mid_i,
  output logic                valid_o,
  output f32asm_pkg::fin_t    fin_o
);
  import f32asm_pkg::*;

  localparam int unsigned LzW = $clog2(ProdW + 1);

  logic [LzW-1:0] lz;
  logic signed [ExtExpW-1:0] msb, en, sh, lim;
  logic [ProdW-1:0] shifted;
  fin_t fin_d, fin_q;
  logic valid_q;

  always_comb begin
    lz = lead_zeros(mid_i.val);
    msb = ExtExpW'(ProdW - 1) - ExtExpW'(lz);
    fin_d.sign = mid_i.sign;
    fin_d.force_zero_sign = mid_i.is_sub;
    fin_d.exp = mid_i.exp;
    fin_d.sig = '0;
    en = '0;
    sh = '0;
    lim = '0;
    shifted = '0;
    if (mid_i.val == '0) begin
      fin_d.sig = '0;
    end else if (mid_i.is_mul) begin
      en = mid_i.exp + msb - ExtExpW'(2 * FracW);
      if (en >= 1) begin
        fin_d.exp = en;
        sh = msb - ExtExpW'(FracW);
      end else begin
        fin_d.exp = ExtExpW'(1);
        sh = ExtExpW'(FracW + 1) - mid_i.exp;
      end
      if (sh < 0) begin
        shifted = mid_i.val << (-sh);
      end else if (sh >= ExtExpW'(ProdW)) begin
        shifted = '0;
      end else begin
        shifted = mid_i.val >> sh;
      end
      fin_d.sig = shifted[SigW-1:0];
    end else if (!mid_i.is_sub) begin
      if (mid_i.val[SigW]) begin
        fin_d.sig = mid_i.val[SigW:1];
        fin_d.exp = mid_i.exp + ExtExpW'(1);
      end else begin
        fin_d.sig = mid_i.val[SigW-1:0];
      end
    end else begin
      // Shift left until normalized or the exponent reaches one.
      sh = ExtExpW'(lz) - ExtExpW'(ProdW - SigW);
      lim = mid_i.exp - ExtExpW'(1);
      if (sh > lim) begin
        sh = lim;
      end
      shifted = mid_i.val << sh;
      fin_d.sig = shifted[SigW-1:0];
      fin_d.exp = mid_i.exp - sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      fin_q <= fin_d;
    end
  end

  assign valid_o = valid_q;
  assign fin_o = fin_q;
endmodule

[src/f32asm_pack.sv]
// Pack stage: zero, overflow and denormal detection and the result register.
module f32asm_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  f32asm_pkg::fin_t    fin_i,
  output logic                valid_o,
  output f32asm_pkg::rsp_t    rsp_o
);
  import f32asm_pkg::*;

  rsp_t rsp_d, rsp_q;
  logic valid_q;

  always_comb begin
    rsp_d.r_sign = fin_i.sign;
    rsp_d.r_exp = '0;
    rsp_d.r_man = '0;
    rsp_d.status = ST_ZERO;
    if (fin_i.sig == '0) begin
      if (fin_i.force_zero_sign) begin
        rsp_d.r_sign = 1'b0;
      end
    end else if (fin_i.exp > ExtExpW'(MaxFiniteExp)) begin
      rsp_d.r_exp = '1;
      rsp_d.status = ST_OVERFLOW;
    end else if (!fin_i.sig[SigW-1]) begin
      rsp_d.r_man = fin_i.sig[FracW-1:0];
    end else begin
      rsp_d.r_exp = fin_i.exp[ExpW-1:0];
      rsp_d.r_man = fin_i.sig[FracW-1:0];
      rsp_d.status = ST_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o = rsp_q;
endmodule

[src/float32_add_sub_mul_unit.sv]
// Top level of the binary32 add, subtract and multiply unit.
// A beat is taken on every cycle with start high; busy is always low. Each
// result appears for exactly one cycle with done_o high, and the receiver
// cannot stall. The result passes through three registered stages: align or
// multiply, normalize, pack.
module float32_add_sub_mul_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  f32asm_pkg::req_t    req_i,
  output logic                done_o,
  output f32asm_pkg::rsp_t    rsp_o
);
  import f32asm_pkg::*;

  logic v1, v2;
  mid_t mid;
  fin_t fin;

  assign busy = 1'b0;

  f32asm_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(start && !busy), .req_i(req_i),
    .valid_o(v1), .mid_o(mid)
  );

  f32asm_norm u_norm (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v1), .mid_i(mid),
    .valid_o(v2), .fin_o(fin)
  );

  f32asm_pack u_pack (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v2), .fin_i(fin),
    .valid_o(done_o), .rsp_o(rsp_o)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##2 done_o) else $error("result beat missing");
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_OVERFLOW) |-> (rsp_o.r_exp == 8'hFF && rsp_o.r_man == '0))
    else $error("bad overflow encoding");
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_NORMAL) |-> (rsp_o.r_exp != '0 && rsp_o.r_exp != 8'hFF))
    else $error("bad normal exponent");
`endif
endmodule

[tb/float32_add_sub_mul_unit_tb.sv]
// Self-checking testbench for the binary32 add, subtract and multiply unit.
`timescale 1ns / 1ps

module float32_add_sub_mul_unit_tb;
  import f32asm_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned Latency = 3;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  req_t pending_ops[$];
  rsp_t expected_rsps[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned idle_pct;

  float32_add_sub_mul_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .done_o(done_o),
    .rsp_o(rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic rsp_t pack_rsp(logic s, int e, logic [63:0] sig);
    rsp_t r;
    r.r_sign = s;
    if (sig == 0) begin
      r.r_exp = '0;
      r.r_man = '0;
      r.status = ST_ZERO;
    end else if (e > int'(MaxFiniteExp)) begin
      r.r_exp = 8'hFF;
      r.r_man = '0;
      r.status = ST_OVERFLOW;
    end else if (sig < 64'(1) << FracW) begin
      r.r_exp = '0;
      r.r_man = sig[FracW-1:0];
      r.status = ST_ZERO;
    end else begin
      r.r_exp = e[7:0];
      r.r_man = sig[FracW-1:0];
      r.status = ST_NORMAL;
    end
    return r;
  endfunction

  function automatic rsp_t fp_compute(req_t q);
    logic [63:0] ga, gb, gl, gs, al, acc;
    logic [127:0] prod;
    int ea, eb, el, d, e, msb, en, sh;
    logic sa, sb, a_big, s;
    ea = int'(q.a_exp);
    eb = int'(q.b_exp);
    ga = {40'd0, q.a_exp != 0, q.a_man};
    gb = {40'd0, q.b_exp != 0, q.b_man};
    if (ea == 0) ea = 1;
    if (eb == 0) eb = 1;
    sa = q.a_sign;
    sb = q.b_sign;
    if (q.req_type == OP_MUL || q.req_type == OP_MUL_ALT) begin
      s = sa ^ sb;
      prod = ga * gb;
      if (prod == 0) return pack_rsp(s, 1, 0);
      msb = 0;
      for (int i = 0; i < 128; i++) if (prod[i]) msb = i;
      e = ea + eb - int'(ExpBias);
      en = e + msb - 2 * int'(FracW);
      if (en >= 1) begin
        sh = msb - int'(FracW);
      end else begin
        sh = int'(FracW) + 1 - e;
        en = 1;
      end
      if (sh < 0) acc = (sh <= -64) ? 64'd0 : prod[63:0] << (-sh);
      else acc = (sh >= 128) ? 64'd0 : 64'(prod >> sh);
      return pack_rsp(s, en, acc);
    end
    if (q.req_type == OP_SUB) sb = ~sb;
    a_big = (ea > eb) || (ea == eb && ga >= gb);
    gl = a_big ? ga : gb;
    gs = a_big ? gb : ga;
    el = a_big ? ea : eb;
    d = a_big ? ea - eb : eb - ea;
    if (sa == sb) begin
      al = (d >= 64) ? 64'd0 : gs >> d;
      acc = gl + al;
      if (acc >= (64'(2) << FracW)) begin
        acc = acc >> 1;
        el++;
      end
      return pack_rsp(sa, el, acc);
    end
    s = a_big ? sa : sb;
    if (d == 0) al = gs;
    else if (d >= 63) al = 0;
    else al = (gs + (64'(1) << (d - 1))) >> d;
    acc = (al > gl) ? 64'd0 : gl - al;
    if (acc == 0) return pack_rsp(1'b0, 1, 0);
    while (acc < (64'(1) << FracW) && el > 1) begin
      acc = acc << 1;
      el--;
    end
    return pack_rsp(s, el, acc);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic logic [7:0] pick_exp();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 3));
      3: return 8'($urandom_range(250, 255));
      4, 5: return 8'($urandom_range(110, 145));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [22:0] pick_man();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 23'($urandom_range(0, 15));
      default: return 23'($urandom());
    endcase
  endfunction

  function automatic req_t rand_op();
    req_t q;
    q.req_type = 2'($urandom_range(0, 3));
    q.a_sign = 1'($urandom());
    q.b_sign = 1'($urandom());
    q.a_exp = pick_exp();
    q.a_man = pick_man();
    if ($urandom_range(0, 3) == 0) begin
      q.b_exp = 8'(int'(q.a_exp) + $urandom_range(0, 2));
      q.b_man = ($urandom_range(0, 1) == 0) ? q.a_man : 23'(q.a_man + $urandom_range(0, 3));
    end else begin
      q.b_exp = pick_exp();
      q.b_man = pick_man();
    end
    return q;
  endfunction

  function automatic req_t make_op(op_e op, logic sa, logic [7:0] ea, logic [22:0] ma,
                                   logic sb, logic [7:0] eb, logic [22:0] mb);
    req_t q;
    q.req_type = op;
    q.a_sign = sa;
    q.a_exp = ea;
    q.a_man = ma;
    q.b_sign = sb;
    q.b_exp = eb;
    q.b_man = mb;
    return q;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && !(start && busy)) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        req_i <= pending_ops.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && start && !busy) expected_rsps.push_back(fp_compute(req_i));
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected beat", 32'(rsp_o), 32'(0));
      end else begin
        rsp_t want;
        want = expected_rsps.pop_front();
        if (rsp_o.r_sign !== want.r_sign)
          report_mismatch("r_sign", 32'(rsp_o.r_sign), 32'(want.r_sign));
        if (rsp_o.r_exp !== want.r_exp)
          report_mismatch("r_exp", 32'(rsp_o.r_exp), 32'(want.r_exp));
        if (rsp_o.r_man !== want.r_man)
          report_mismatch("r_man", 32'(rsp_o.r_man), 32'(want.r_man));
        if (rsp_o.status !== want.status)
          report_mismatch("status", 32'(rsp_o.status), 32'(want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    idle_pct = 8;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    pending_ops.push_back(make_op(OP_ADD, 0, 8'd127, 0, 0, 8'd127, 0));
    pending_ops.push_back(make_op(OP_SUB, 0, 8'd127, 0, 0, 8'd127, 0));
    pending_ops.push_back(make_op(OP_ADD, 1, 8'd130, 23'h7FFFFF, 0, 8'd130, 23'h7FFFFF));
    pending_ops.push_back(make_op(OP_MUL, 0, 8'd0, 0, 1, 8'd200, 23'h123));
    pending_ops.push_back(make_op(OP_MUL_ALT, 1, 8'd130, 23'h400000, 1, 8'd120, 23'h1));
    pending_ops.push_back(make_op(OP_ADD, 0, 8'd255, 23'h7FFFFF, 0, 8'd255, 23'h7FFFFF));
    pending_ops.push_back(make_op(OP_MUL, 0, 8'd255, 23'h7FFFFF, 1, 8'd255, 23'h7FFFFF));
    pending_ops.push_back(make_op(OP_MUL, 0, 8'd1, 0, 0, 8'd1, 0));
    pending_ops.push_back(make_op(OP_MUL, 1, 8'd60, 23'h7FFFFF, 0, 8'd60, 23'h7FFFFF));
    pending_ops.push_back(make_op(OP_MUL, 0, 8'd0, 23'h7FFFFF, 0, 8'd127, 0));
    pending_ops.push_back(make_op(OP_ADD, 0, 8'd0, 23'h400000, 0, 8'd0, 23'h400000));
    pending_ops.push_back(make_op(OP_SUB, 1, 8'd0, 23'h000003, 1, 8'd0, 23'h000001));
    pending_ops.push_back(make_op(OP_SUB, 0, 8'd1, 0, 0, 8'd0, 23'h7FFFFF));
    pending_ops.push_back(make_op(OP_SUB, 0, 8'd127, 0, 0, 8'd102, 23'h7FFFFF));
    pending_ops.push_back(make_op(OP_SUB, 0, 8'd3, 0, 0, 8'd2, 23'h7FFFFF));
    pending_ops.push_back(make_op(OP_ADD, 0, 8'd200, 0, 1, 8'd10, 23'h1));
    pending_ops.push_back(make_op(OP_SUB, 1, 8'd254, 23'h7FFFFF, 0, 8'd254, 23'h7FFFFF));
    pending_ops.push_back(make_op(OP_ADD, 0, 8'd0, 0, 1, 8'd0, 0));
    pending_ops.push_back(make_op(OP_SUB, 0, 8'd140, 23'h1, 0, 8'd140, 23'h0));

    for (int i = 0; i < 1550; i++) begin
      if (i == 520) begin
        while (pending_ops.size() != 0) @(negedge clk_i);
        idle_pct = 82;
      end
      if (i == 1040) begin
        while (pending_ops.size() != 0) @(negedge clk_i);
        idle_pct = 0;
      end
      pending_ops.push_back(rand_op());
    end

    while (pending_ops.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    while (start) @(negedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/f32asm_pkg.sv
src/f32asm_front.sv
src/f32asm_norm.sv
src/f32asm_pack.sv
src/float32_add_sub_mul_unit.sv
tb/float32_add_sub_mul_unit_tb.sv
